@@ rtl/hse_pkg.sv @@
`default_nettype none
package hse_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_STATS  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  localparam int COUNT_W = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // iterative divider request / response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [23:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INS_RD,
    ST_INS_WR,
    ST_WALK,
    ST_DIV_BIN,
    ST_DIV_CUM,
    ST_DIV_MQ,
    ST_DIV_MF,
    ST_VAR_WALK,
    ST_VAR_MUL,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/hse_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle, 64 by 24 bits
module hse_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hse_pkg::div_req_t req,
  output hse_pkg::div_rsp_t      rsp
);
  logic [63:0] quo;
  logic [24:0] rem;
  logic [23:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [24:0] trial;
  logic [24:0] shifted;

  always_comb begin
    shifted = {rem[23:0], quo[63]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[24]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem[23:0]};

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without work");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.den != 24'd0) else $error("zero divisor");
  a_den_stable: assert property (@(posedge clk) disable iff (rst)
    busy && !req.start && $past(busy) |-> $stable(den)) else $error("divisor moved");
`endif
endmodule
`default_nettype wire

@@ rtl/histogram_statistics_engine.sv @@
`default_nettype none
// insert reads and rewrites the bin; read walks up to bin and divides twice;
//   statistics walk to top (top = highest valid bin), divide, walk, divide, sqrt
// throughput: one word at a time, the next is taken the cycle after the result word
//   leaves; set by the count memory walk and the bit-serial divider
// the memory is swept to zero after reset before items are taken
// a clear word also sweeps the memory, one entry a cycle
module histogram_statistics_engine #(
  parameter int MAX_BINS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  bin,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic [31:0]      bin_freq,
  output logic [31:0]      cum_freq,
  output logic [23:0]      mean,
  output logic [31:0]      variance,
  output logic [23:0]      std_dev
);
  localparam int AW = $clog2(MAX_BINS);
  localparam logic [AW-1:0] LAST = AW'(MAX_BINS - 1);

  // configuration
  logic [7:0]  num_bins;
  logic [23:0] elem_total;
  logic [23:0] norm;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins   <= 8'd255;
      elem_total <= 24'd1;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) num_bins <= cfg_data[7:0];
      else                   elem_total <= cfg_data;
    end
  end
  assign norm = (elem_total == 24'd0) ? 24'd1 : elem_total;

  // highest valid bin, limited by the store depth
  logic [AW-1:0] top;
  always_comb begin
    if ({24'd0, num_bins} > 32'(MAX_BINS - 1)) top = LAST;
    else top = AW'(num_bins);
  end

  // count memory, one read and one write port
  logic [23:0]   mem [MAX_BINS];
  logic [AW-1:0] rd_addr, wr_addr;
  logic [23:0]   rd_data, wr_data;
  logic          wr_en;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // divider
  hse_pkg::div_req_t dreq;
  hse_pkg::div_rsp_t drsp;
  hse_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // control registers
  hse_pkg::state_t state, state_next;
  logic [AW-1:0] idx;       // walk pointer
  logic          rd_ok;     // rd_data valid for idx-1
  logic [AW-1:0] req_bin;
  logic [23:0]   cur;       // count of the addressed bin
  logic [63:0]   sum;       // running sum (counts or i*count)
  logic [63:0]   acc;       // variance accumulator
  logic          vsat;
  logic [23:0]   mean_q;
  logic [31:0]   d2;        // truncated squared deviation
  logic [23:0]   cnt_reg;   // count for the multiply stage
  logic [63:0]   sq_x;      // square root remainder
  logic [63:0]   sq_r;
  logic [63:0]   sq_b;
  logic [5:0]    sq_n;
  logic          is_read;
  logic          sweep;     // reset sweep in progress
  logic          dstart_q;

  // combinational helpers
  logic          in_acc;
  logic          bin_bad;
  logic [AW-1:0] prev;
  logic [63:0]   pos;
  logic [63:0]   dev;
  logic [63:0]   dsq;
  logic [63:0]   prod;
  logic [63:0]   limit;
  logic [63:0]   sq_t;

  assign in_stall = sweep || (state != hse_pkg::ST_IDLE) || out_valid;
  assign in_acc   = in_valid && !in_stall;
  assign bin_bad  = {24'd0, bin} > {{(32-AW){1'b0}}, top};
  assign prev     = idx - AW'(1);
  assign pos      = {{(48-AW){1'b0}}, prev, 16'd0};
  assign dev      = (pos >= {40'd0, mean_q}) ? pos - {40'd0, mean_q}
                                             : {40'd0, mean_q} - pos;
  assign dsq      = dev[31:0] * dev[31:0];
  assign prod     = {40'd0, cnt_reg} * {32'd0, d2};
  assign limit    = {8'd0, norm, 32'd0};
  assign sq_t     = sq_r + sq_b;

  always_comb begin
    state_next = state;
    unique case (state)
      hse_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            hse_pkg::KIND_INSERT: state_next = bin_bad ? hse_pkg::ST_OUT : hse_pkg::ST_INS_RD;
            hse_pkg::KIND_READ:   state_next = bin_bad ? hse_pkg::ST_OUT : hse_pkg::ST_WALK;
            hse_pkg::KIND_STATS:  state_next = hse_pkg::ST_WALK;
            hse_pkg::KIND_CLEAR:  state_next = hse_pkg::ST_CLEAR;
            default:              state_next = hse_pkg::ST_IDLE;
          endcase
        end
      end
      hse_pkg::ST_CLEAR:    if (idx == LAST) state_next = hse_pkg::ST_OUT;
      hse_pkg::ST_INS_RD:   state_next = hse_pkg::ST_INS_WR;
      hse_pkg::ST_INS_WR:   state_next = hse_pkg::ST_OUT;
      hse_pkg::ST_WALK: begin
        if (rd_ok && prev == (is_read ? req_bin : top))
          state_next = is_read ? hse_pkg::ST_DIV_BIN : hse_pkg::ST_DIV_MQ;
      end
      hse_pkg::ST_DIV_BIN:  if (drsp.done) state_next = hse_pkg::ST_DIV_CUM;
      hse_pkg::ST_DIV_CUM:  if (drsp.done) state_next = hse_pkg::ST_OUT;
      hse_pkg::ST_DIV_MQ:   if (drsp.done) state_next = (drsp.quo >= 64'd256) ?
                              hse_pkg::ST_VAR_WALK : hse_pkg::ST_DIV_MF;
      hse_pkg::ST_DIV_MF:   if (drsp.done) state_next = hse_pkg::ST_VAR_WALK;
      hse_pkg::ST_VAR_WALK: if (rd_ok) state_next = hse_pkg::ST_VAR_MUL;
      hse_pkg::ST_VAR_MUL:  state_next = (vsat || prev == top) ? hse_pkg::ST_DIV_VAR
                                                              : hse_pkg::ST_VAR_WALK;
      hse_pkg::ST_DIV_VAR:  if (vsat || drsp.done) state_next = hse_pkg::ST_SQRT;
      hse_pkg::ST_SQRT:     if (sq_n == 6'd0) state_next = hse_pkg::ST_OUT;
      hse_pkg::ST_OUT:      state_next = hse_pkg::ST_IDLE;
      default:              state_next = hse_pkg::ST_IDLE;
    endcase
  end

  // memory port and divider drive
  always_comb begin
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = '0;
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = norm;
    if (sweep || state == hse_pkg::ST_CLEAR) wr_en = 1'b1;
    if (state == hse_pkg::ST_IDLE) rd_addr = AW'(bin);
    if (state == hse_pkg::ST_INS_RD) rd_addr = req_bin;
    if (state == hse_pkg::ST_INS_WR) begin
      wr_en   = (rd_data != hse_pkg::COUNT_MAX);
      wr_addr = req_bin;
      wr_data = rd_data + 24'd1;
    end
    if (dstart_q) begin
      dreq.start = 1'b1;
      unique case (state)
        hse_pkg::ST_DIV_BIN: dreq.num = {16'd0, cur, 24'd0};
        hse_pkg::ST_DIV_CUM: dreq.num = {sum[39:0], 24'd0};
        hse_pkg::ST_DIV_MQ:  dreq.num = sum;
        hse_pkg::ST_DIV_MF:  dreq.num = {24'd0, drsp.rem, 16'd0};
        hse_pkg::ST_DIV_VAR: dreq.num = acc;
        default:             dreq.num = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hse_pkg::ST_IDLE;
      out_valid <= 1'b0;
      sweep     <= 1'b1;
      idx       <= '0;
      rd_ok     <= 1'b0;
      dstart_q  <= 1'b0;
    end else begin
      state    <= (sweep) ? hse_pkg::ST_IDLE : state_next;
      dstart_q <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (sweep) begin
        idx <= idx + AW'(1);
        if (idx == LAST) begin
          sweep <= 1'b0;
          idx   <= '0;
        end
      end else begin
        unique case (state)
          hse_pkg::ST_IDLE: begin
            if (in_acc) begin
              is_read  <= (kind == hse_pkg::KIND_READ);
              req_bin  <= AW'(bin);
              idx      <= '0;
              rd_ok    <= 1'b0;
              sum      <= '0;
              acc      <= '0;
              vsat     <= 1'b0;
              status   <= ((kind == hse_pkg::KIND_INSERT) || (kind == hse_pkg::KIND_READ))
                          && bin_bad;
              bin_freq <= '0;
              cum_freq <= '0;
              mean     <= '0;
              variance <= '0;
              std_dev  <= '0;
            end
          end
          hse_pkg::ST_CLEAR: begin
            idx <= idx + AW'(1);
            if (idx == LAST) idx <= '0;
          end
          hse_pkg::ST_WALK: begin
            idx   <= idx + AW'(1);
            rd_ok <= 1'b1;
            if (rd_ok) begin
              if (is_read) sum <= sum + {40'd0, rd_data};
              else sum <= sum + ({40'd0, rd_data} * {{(64-AW){1'b0}}, prev});
              cur <= rd_data;
              if (state_next != hse_pkg::ST_WALK) dstart_q <= 1'b1;
            end
          end
          hse_pkg::ST_DIV_BIN: if (drsp.done) begin
            bin_freq <= (drsp.quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : drsp.quo[31:0];
            dstart_q <= 1'b1;
          end
          hse_pkg::ST_DIV_CUM: if (drsp.done)
            cum_freq <= (drsp.quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : drsp.quo[31:0];
          hse_pkg::ST_DIV_MQ: if (drsp.done) begin
            idx   <= '0;
            rd_ok <= 1'b0;
            if (drsp.quo >= 64'd256) mean_q <= 24'hFF_FFFF;
            else begin
              mean_q   <= {drsp.quo[7:0], 16'd0};
              dstart_q <= 1'b1;
            end
          end
          hse_pkg::ST_DIV_MF: if (drsp.done) mean_q[15:0] <= drsp.quo[15:0];
          hse_pkg::ST_VAR_WALK: begin
            if (!rd_ok) begin
              idx   <= idx + AW'(1);
              rd_ok <= 1'b1;
            end else begin
              cnt_reg <= rd_data;
              d2      <= dsq[47:16];
            end
          end
          hse_pkg::ST_VAR_MUL: begin
            rd_ok <= 1'b0;
            if (prod >= limit - acc) vsat <= 1'b1;
            else acc <= acc + prod;
            // no divide once the sum has saturated
            if (state_next == hse_pkg::ST_DIV_VAR)
              dstart_q <= !vsat && !(prod >= limit - acc);
          end
          hse_pkg::ST_DIV_VAR: begin
            if (vsat || drsp.done) begin
              variance <= vsat ? 32'hFFFF_FFFF : drsp.quo[31:0];
              sq_x <= vsat ? 64'hFFFF_FFFF_0000 : {drsp.quo[47:0], 16'd0};
              sq_r <= '0;
              sq_b <= 64'h4000_0000_0000_0000;
              sq_n <= 6'd32;
            end
          end
          hse_pkg::ST_SQRT: begin
            if (sq_x >= sq_t) begin
              sq_x <= sq_x - sq_t;
              sq_r <= (sq_r >> 1) + sq_b;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_b <= sq_b >> 2;
            sq_n <= sq_n - 6'd1;
            if (sq_n == 6'd0) begin
              mean    <= mean_q;
              std_dev <= sq_r[23:0];
            end
          end
          hse_pkg::ST_OUT: out_valid <= 1'b1;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> state == hse_pkg::ST_IDLE && !sweep) else $error("accept while busy");
  a_out_after_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == hse_pkg::ST_OUT) else $error("stray word");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> sweep || state == hse_pkg::ST_CLEAR || state == hse_pkg::ST_INS_WR)
    else $error("unexpected write");
`endif
endmodule
`default_nettype wire
